### src/vwi_pkg.sv
`timescale 1ns / 1ps

package vwi_pkg;

    // Table geometry and coordinate format.
    localparam int VERTEX_DEPTH = 1024;
    localparam int COORD_BITS   = 32;
    localparam int IDX_BITS     = $clog2(VERTEX_DEPTH);
    localparam int CNT_BITS     = $clog2(VERTEX_DEPTH + 1);
    localparam int OUT_IDX_BITS = 10;
    localparam int IN_BITS      = 32;
    localparam int MAT_BITS     = 32;

    // Distance arithmetic widths.
    localparam int WELD_BITS  = 31;
    localparam int LIM_BITS   = 2 * WELD_BITS;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int LIMIT_BITS = 64;
    localparam int CMP_BITS   = (SUM_BITS > LIMIT_BITS) ? SUM_BITS : LIMIT_BITS + 1;

    // Vertices per triangle.
    localparam int NUM_VERTS = 3;
    localparam int VSEL_BITS = $clog2(NUM_VERTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FINISH
    } t_vwi_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic issue;
        logic rec_hit;
        logic append;
        logic overflow;
        logic next_vertex;
        logic publish;
    } t_vwi_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_done;
        logic pipe_busy;
        logic hit;
        logic table_full;
        logic last_vertex;
        logic out_free;
    } t_vwi_status;

endpackage

### src/vwi_ctrl.sv
`timescale 1ns / 1ps

module vwi_ctrl
    import vwi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_vwi_status i_status,
    output t_vwi_cmd    o_cmd
);

    t_vwi_state r_state;
    t_vwi_state n_state;
    logic       resolved;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        resolved = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                o_cmd.scan_start = 1'b1;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                // The pipeline returns results in address order, so the first hit wins.
                if (i_status.hit) begin
                    o_cmd.rec_hit = 1'b1;
                    resolved      = 1'b1;
                end else if (i_status.addr_done && !i_status.pipe_busy) begin
                    if (i_status.table_full) begin
                        o_cmd.overflow = 1'b1;
                    end else begin
                        o_cmd.append = 1'b1;
                    end
                    resolved = 1'b1;
                end else if (!i_status.addr_done) begin
                    o_cmd.issue = 1'b1;
                end
                if (resolved) begin
                    if (i_status.last_vertex) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.next_vertex = 1'b1;
                        n_state           = ST_START;
                    end
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### src/vwi_datapath.sv
`timescale 1ns / 1ps

module vwi_datapath
    import vwi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [WELD_BITS-1:0]    i_cfg_weld_distance,
    input  logic                    i_first_of_mesh,
    input  logic [IN_BITS-1:0]      i_a_x,
    input  logic [IN_BITS-1:0]      i_a_y,
    input  logic [IN_BITS-1:0]      i_a_z,
    input  logic [IN_BITS-1:0]      i_b_x,
    input  logic [IN_BITS-1:0]      i_b_y,
    input  logic [IN_BITS-1:0]      i_b_z,
    input  logic [IN_BITS-1:0]      i_c_x,
    input  logic [IN_BITS-1:0]      i_c_y,
    input  logic [IN_BITS-1:0]      i_c_z,
    input  logic [MAT_BITS-1:0]     i_material,
    input  t_vwi_cmd                i_cmd,
    output t_vwi_status             o_status,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic [OUT_IDX_BITS-1:0] o_index_a,
    output logic [OUT_IDX_BITS-1:0] o_index_b,
    output logic [OUT_IDX_BITS-1:0] o_index_c,
    output logic [MAT_BITS-1:0]     o_material_out,
    output logic [NUM_VERTS-1:0]    o_new_vertex_mask,
    output logic                    o_keep,
    output logic                    o_table_overflow
);

    // Magnitude of the difference of two coordinates; it always fits COORD_BITS bits.
    function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] p,
                                                        input logic [COORD_BITS-1:0] q);
        logic signed [COORD_BITS:0] d;
        d = $signed({p[COORD_BITS-1], p}) - $signed({q[COORD_BITS-1], q});
        return d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
    endfunction

    // Unique-vertex store.
    logic [COORD_BITS-1:0] mem_x [VERTEX_DEPTH];
    logic [COORD_BITS-1:0] mem_y [VERTEX_DEPTH];
    logic [COORD_BITS-1:0] mem_z [VERTEX_DEPTH];

    logic [WELD_BITS-1:0]  r_weld;
    logic [LIM_BITS-1:0]   r_lim;

    logic [COORD_BITS-1:0] r_vx [NUM_VERTS];
    logic [COORD_BITS-1:0] r_vy [NUM_VERTS];
    logic [COORD_BITS-1:0] r_vz [NUM_VERTS];
    logic [MAT_BITS-1:0]   r_mat;
    logic [VSEL_BITS-1:0]  r_vsel;
    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   r_addr;

    logic [IDX_BITS-1:0]   r_idx [NUM_VERTS];
    logic [NUM_VERTS-1:0]  r_mask;
    logic                  r_ovf;

    // Search pipeline registers.
    logic                  r_v1, r_v2, r_v3, r_v4, r_hit;
    logic [IDX_BITS-1:0]   r_i1, r_i2, r_i3, r_i4, r_i5;
    logic [COORD_BITS-1:0] r_rd_x, r_rd_y, r_rd_z;
    logic [COORD_BITS-1:0] r_m_x, r_m_y, r_m_z;
    logic [SQ_BITS-1:0]    r_sq_x, r_sq_y, r_sq_z;
    logic [SUM_BITS-1:0]   r_sum;

    logic [COORD_BITS-1:0] cur_x, cur_y, cur_z;
    logic [CMP_BITS-1:0]   sum_ext;
    logic                  in_radius;
    logic                  keep;

    assign cur_x = r_vx[r_vsel];
    assign cur_y = r_vy[r_vsel];
    assign cur_z = r_vz[r_vsel];

    // Weld radius and its square; the square is registered from the radius in the cycle after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weld <= '0;
            r_lim  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_weld <= i_cfg_weld_distance;
            end
            r_lim <= r_weld * r_weld;
        end
    end

    // Triangle capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vx[0] <= i_a_x[COORD_BITS-1:0];
            r_vy[0] <= i_a_y[COORD_BITS-1:0];
            r_vz[0] <= i_a_z[COORD_BITS-1:0];
            r_vx[1] <= i_b_x[COORD_BITS-1:0];
            r_vy[1] <= i_b_y[COORD_BITS-1:0];
            r_vz[1] <= i_b_z[COORD_BITS-1:0];
            r_vx[2] <= i_c_x[COORD_BITS-1:0];
            r_vy[2] <= i_c_y[COORD_BITS-1:0];
            r_vz[2] <= i_c_z[COORD_BITS-1:0];
            r_mat   <= i_material;
        end
    end

    // Table fill count, vertex select and per-triangle flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_vsel  <= '0;
            r_mask  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_vsel <= '0;
                r_mask <= '0;
                r_ovf  <= 1'b0;
                if (i_first_of_mesh) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.append) begin
                r_count         <= r_count + CNT_BITS'(1);
                r_mask[r_vsel] <= 1'b1;
            end
            if (i_cmd.overflow) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.next_vertex) begin
                r_vsel <= r_vsel + VSEL_BITS'(1);
            end
        end
    end

    // Index chosen for the current vertex.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_hit) begin
            r_idx[r_vsel] <= r_i5;
        end else if (i_cmd.append) begin
            r_idx[r_vsel] <= r_count[IDX_BITS-1:0];
        end else if (i_cmd.overflow) begin
            r_idx[r_vsel] <= '0;
        end
    end

    // Store write for an appended vertex and registered read for the search.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem_x[r_count[IDX_BITS-1:0]] <= cur_x;
            mem_y[r_count[IDX_BITS-1:0]] <= cur_y;
            mem_z[r_count[IDX_BITS-1:0]] <= cur_z;
        end
        r_rd_x <= mem_x[r_addr[IDX_BITS-1:0]];
        r_rd_y <= mem_y[r_addr[IDX_BITS-1:0]];
        r_rd_z <= mem_z[r_addr[IDX_BITS-1:0]];
    end

    // Search address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.scan_start) begin
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + CNT_BITS'(1);
        end
    end

    // Valid tags of the search pipeline; a new scan flushes them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_start) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1  <= i_cmd.issue;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_hit <= r_v4 && in_radius;
        end
    end

    // Distance stages: magnitudes, squares, sum.
    always_ff @(posedge i_clk) begin
        r_i1   <= r_addr[IDX_BITS-1:0];
        r_i2   <= r_i1;
        r_i3   <= r_i2;
        r_i4   <= r_i3;
        r_i5   <= r_i4;
        r_m_x  <= abs_diff(r_rd_x, cur_x);
        r_m_y  <= abs_diff(r_rd_y, cur_y);
        r_m_z  <= abs_diff(r_rd_z, cur_z);
        r_sq_x <= r_m_x * r_m_x;
        r_sq_y <= r_m_y * r_m_y;
        r_sq_z <= r_m_z * r_m_z;
        r_sum  <= SUM_BITS'(r_sq_x) + SUM_BITS'(r_sq_y) + SUM_BITS'(r_sq_z);
    end

    // A sum beyond the 64-bit range never welds.
    assign sum_ext   = CMP_BITS'(r_sum);
    assign in_radius = ((sum_ext >> LIMIT_BITS) == '0)
                       && (sum_ext[LIMIT_BITS-1:0] <= LIMIT_BITS'(r_lim));

    assign keep = !r_ovf && (r_idx[0] != r_idx[1]) && (r_idx[0] != r_idx[2])
                  && (r_idx[1] != r_idx[2]);

    // Output register: holds a finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_index_a         <= OUT_IDX_BITS'(r_idx[0]);
            o_index_b         <= OUT_IDX_BITS'(r_idx[1]);
            o_index_c         <= OUT_IDX_BITS'(r_idx[2]);
            o_material_out    <= r_mat;
            o_new_vertex_mask <= r_mask;
            o_keep            <= keep;
            o_table_overflow  <= r_ovf;
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.addr_done   = (r_addr == r_count);
        o_status.pipe_busy   = r_v1 || r_v2 || r_v3 || r_v4;
        o_status.hit         = r_hit;
        o_status.table_full  = (r_count == CNT_BITS'(VERTEX_DEPTH));
        o_status.last_vertex = (r_vsel == VSEL_BITS'(NUM_VERTS - 1));
        o_status.out_free    = !o_out_valid || !i_out_stall;
    end

endmodule

### src/vertex_weld_indexer_top.sv
// Operation: an accepted triangle is resolved vertex by vertex, each search covering the n stored
// vertices (at most 1024); the result is published once the output register is free.
// Throughput: one triangle at a time; each vertex scans the table one entry per cycle through
// a single read port, followed by a five-stage distance pipeline.
// Reset: synchronous, active low; clears the vertex count, weld distance and handshake state.
`timescale 1ns / 1ps

module vertex_weld_indexer_top
    import vwi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [WELD_BITS-1:0]    i_cfg_weld_distance,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_first_of_mesh,
    input  logic [IN_BITS-1:0]      i_a_x,
    input  logic [IN_BITS-1:0]      i_a_y,
    input  logic [IN_BITS-1:0]      i_a_z,
    input  logic [IN_BITS-1:0]      i_b_x,
    input  logic [IN_BITS-1:0]      i_b_y,
    input  logic [IN_BITS-1:0]      i_b_z,
    input  logic [IN_BITS-1:0]      i_c_x,
    input  logic [IN_BITS-1:0]      i_c_y,
    input  logic [IN_BITS-1:0]      i_c_z,
    input  logic [MAT_BITS-1:0]     i_material,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [OUT_IDX_BITS-1:0] o_index_a,
    output logic [OUT_IDX_BITS-1:0] o_index_b,
    output logic [OUT_IDX_BITS-1:0] o_index_c,
    output logic [MAT_BITS-1:0]     o_material_out,
    output logic [NUM_VERTS-1:0]    o_new_vertex_mask,
    output logic                    o_keep,
    output logic                    o_table_overflow
);

    t_vwi_cmd    cmd;
    t_vwi_status status;

    // The weld register takes a transaction in every cycle.
    assign o_cfg_ready = 1'b1;

    vwi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vwi_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_weld_distance (i_cfg_weld_distance),
        .i_first_of_mesh     (i_first_of_mesh),
        .i_a_x               (i_a_x),
        .i_a_y               (i_a_y),
        .i_a_z               (i_a_z),
        .i_b_x               (i_b_x),
        .i_b_y               (i_b_y),
        .i_b_z               (i_b_z),
        .i_c_x               (i_c_x),
        .i_c_y               (i_c_y),
        .i_c_z               (i_c_z),
        .i_material          (i_material),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_index_a           (o_index_a),
        .o_index_b           (o_index_b),
        .o_index_c           (o_index_c),
        .o_material_out      (o_material_out),
        .o_new_vertex_mask   (o_new_vertex_mask),
        .o_keep              (o_keep),
        .o_table_overflow    (o_table_overflow)
    );

endmodule

### src/vwi_checker.sv
`timescale 1ns / 1ps

module vwi_checker
    import vwi_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [OUT_IDX_BITS-1:0] o_index_a,
    input logic [OUT_IDX_BITS-1:0] o_index_b,
    input logic [OUT_IDX_BITS-1:0] o_index_c,
    input logic [MAT_BITS-1:0]     o_material_out,
    input logic [NUM_VERTS-1:0]    o_new_vertex_mask,
    input logic                    o_keep,
    input logic                    o_table_overflow
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_index_a)
            && $stable(o_index_b) && $stable(o_index_c) && $stable(o_material_out))
        else $error("result changed while stalled");

    // One triangle at a time: an accepted transaction closes the input.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open straight after an accepted triangle");

    // A kept triangle has no overflow and three distinct indices.
    a_keep_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_keep |-> !o_table_overflow && (o_index_a != o_index_b)
            && (o_index_a != o_index_c) && (o_index_b != o_index_c))
        else $error("keep set on a degenerate or overflowed triangle");

    // Vertices a and b, when both appended, take consecutive indices.
    a_append_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_vertex_mask[0] && o_new_vertex_mask[1]
            |-> o_index_b == OUT_IDX_BITS'(o_index_a + OUT_IDX_BITS'(1)))
        else $error("appended vertices out of order");

endmodule

bind vertex_weld_indexer_top vwi_checker u_vwi_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_index_a         (o_index_a),
    .o_index_b         (o_index_b),
    .o_index_c         (o_index_c),
    .o_material_out    (o_material_out),
    .o_new_vertex_mask (o_new_vertex_mask),
    .o_keep            (o_keep),
    .o_table_overflow  (o_table_overflow)
);
